/* rtl/core/rrts_pkg.sv */
// Package with the constants, codes and types of the round-robin task scheduler.
`default_nettype none
package rrts_pkg;
	localparam int MaxTasks = 16;
	localparam int SlotW = $clog2(MaxTasks);
	localparam int CntW = $clog2(MaxTasks + 1);
	localparam logic [15:0] WaitTicksReset = 16'd10;

	typedef enum logic [2:0] {
		FUNC_TICK = 3'd0,
		FUNC_CREATE = 3'd1,
		FUNC_SLEEP = 3'd2,
		FUNC_EXIT = 3'd3,
		FUNC_WAIT = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One table entry as stored in the task memory.
	typedef struct packed {
		logic [7:0] pid;
		logic [7:0] parent;
		logic [31:0] sleep;
		logic zombie;
		logic runnable;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_TICK_RD,
		S_TICK_WB,
		S_TICK_DONE,
		S_CUR_RD,
		S_CUR_DONE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WB,
		S_SHIFT_END,
		S_WR,
		S_PID_RD,
		S_REPORT
	} state_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic rd;
		logic [SlotW-1:0] rd_addr;
		logic wr;
		logic [SlotW-1:0] wr_addr;
		entry_t wr_data;
	} mem_req_t;
endpackage
`default_nettype wire

/* rtl/core/round_robin_task_scheduler_unit.sv */
// Top level of the round-robin task scheduler with sleep timers.
//  channel | signals                                  | handshake
//  input   | func sleep_count new_parent new_runnable | start high while busy low
//  result  | switch_now current_pid result_pid status | done strobe, one cycle
//  config  | wait_sleep_ticks_we wait_sleep_ticks_wdata | taken on every we edge
// Each table walk reads one slot per cycle from the task memory, and a wait that
// reaps a child scans up to it and then shifts the rest.
// Reset is asynchronous; the first cycle after it clears the kernel slot, busy high.
// The result cannot be stalled; busy stays high until the strobe cycle.
`default_nettype none
module round_robin_task_scheduler_unit
	import rrts_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] func,
	input wire logic [31:0] sleep_count,
	input wire logic [7:0] new_parent,
	input wire logic new_runnable,
	input wire logic wait_sleep_ticks_we,
	input wire logic [15:0] wait_sleep_ticks_wdata,
	output logic done,
	output logic switch_now,
	output logic [7:0] current_pid,
	output logic [7:0] result_pid,
	output logic [1:0] status,
	output logic halted
);
	logic [15:0] wait_q;
	mem_req_t req;
	entry_t rd_data;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= WaitTicksReset;
		end else if (wait_sleep_ticks_we) begin
			wait_q <= wait_sleep_ticks_wdata;
		end
	end

	rrts_table_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

	rrts_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.sleep_count(sleep_count), .new_parent(new_parent), .new_runnable(new_runnable),
		.wait_ticks(wait_q), .rd_data(rd_data), .req(req), .busy(busy), .done(done),
		.switch_now(switch_now), .current_pid(current_pid), .result_pid(result_pid),
		.status(status), .halted(halted)
	);
endmodule
`default_nettype wire

/* rtl/core/rrts_table_ram.sv */
// Task table memory: one write port and one registered read port.
`default_nettype none
module rrts_table_ram
	import rrts_pkg::*;
(
	input wire logic clk,
	input wire mem_req_t req,
	output entry_t rd_data
);
	entry_t mem [MaxTasks];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/rrts_seq.sv */
// Sequencer that walks the task table for each item.
`default_nettype none
module rrts_seq
	import rrts_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [2:0] func,
	input wire logic [31:0] sleep_count,
	input wire logic [7:0] new_parent,
	input wire logic new_runnable,
	input wire logic [15:0] wait_ticks,
	input wire entry_t rd_data,
	output mem_req_t req,
	output logic busy,
	output logic done,
	output logic switch_now,
	output logic [7:0] current_pid,
	output logic [7:0] result_pid,
	output logic [1:0] status,
	output logic halted
);
	state_t state_q, state_next;
	logic [2:0] func_q;
	logic [31:0] sleep_q;
	logic [7:0] parent_q;
	logic runnable_q;
	logic [SlotW-1:0] cur_q;
	logic [CntW-1:0] cnt_q;
	logic [SlotW-1:0] idx_q;
	logic [SlotW-1:0] rm_q;
	logic [SlotW-1:0] aft_q;
	logic aft_v_q;
	logic [SlotW-1:0] bef_q;
	logic bef_v_q;
	logic [7:0] key_q;
	entry_t cur_ent_q;
	logic sw_q;
	status_t st_q;
	logic [7:0] res_q;

	logic last_idx;
	logic [SlotW-1:0] idx_nxt;
	logic [CntW-1:0] cnt_dec;
	logic tick_hit;
	logic scan_hit;
	logic [SlotW-1:0] tick_sel;
	logic tick_v;
	logic [SlotW-1:0] exit_cur;

	assign last_idx = (CntW'(idx_q) + CntW'(1)) >= cnt_q;
	assign idx_nxt = idx_q + SlotW'(1);
	assign cnt_dec = cnt_q - CntW'(1);

	// A tick candidate is judged on its count after the decrement.
	assign tick_hit = (rd_data.pid != 8'd0) && rd_data.runnable && !rd_data.zombie
		&& (rd_data.sleep <= 32'd1);

	// Exit looks for the parent pid, wait for a zombie child of the caller.
	assign scan_hit = (func_q == FUNC_EXIT) ? (rd_data.pid == key_q)
		: (rd_data.parent == key_q && rd_data.zombie);

	// The first hit after the current slot wins, else the first from slot 0.
	assign tick_sel = aft_v_q ? aft_q : bef_q;
	assign tick_v = aft_v_q || bef_v_q;

	// Current slot after an exit without parent removed it.
	always_comb begin
		exit_cur = (CntW'(cur_q) >= cnt_dec) ? '0 : cur_q;
		if (exit_cur == '0 && cnt_dec > CntW'(1)) begin
			exit_cur = SlotW'(1);
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_INIT: state_next = S_IDLE;
			S_IDLE: begin
				if (start) begin
					if (cnt_q == '0) begin
						state_next = S_PID_RD;
					end else begin
						unique case (func)
							FUNC_TICK: state_next = (cnt_q < CntW'(2)) ? S_PID_RD : S_TICK_RD;
							FUNC_CREATE: state_next = (cnt_q >= CntW'(MaxTasks)) ? S_PID_RD : S_WR;
							FUNC_SLEEP: state_next = S_CUR_RD;
							FUNC_EXIT: state_next = S_CUR_RD;
							FUNC_WAIT: state_next = S_CUR_RD;
							default: state_next = S_PID_RD;
						endcase
					end
				end
			end
			S_TICK_RD: state_next = S_TICK_WB;
			S_TICK_WB: state_next = last_idx ? S_TICK_DONE : S_TICK_WB;
			S_TICK_DONE: state_next = S_PID_RD;
			S_CUR_RD: state_next = S_CUR_DONE;
			S_CUR_DONE: begin
				unique case (func_q)
					FUNC_EXIT: state_next = (rd_data.parent != 8'd0) ? S_SCAN_RD : S_SHIFT_RD;
					FUNC_WAIT: state_next = S_SCAN_RD;
					default: state_next = S_PID_RD;
				endcase
			end
			S_SCAN_RD: state_next = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (scan_hit) begin
					state_next = (func_q == FUNC_EXIT) ? S_PID_RD : S_SHIFT_RD;
				end else if (last_idx) begin
					state_next = S_PID_RD;
				end else begin
					state_next = S_SCAN_CHK;
				end
			end
			S_SHIFT_RD: begin
				state_next = (CntW'(rm_q) + CntW'(1) < cnt_q) ? S_SHIFT_WB : S_SHIFT_END;
			end
			S_SHIFT_WB: begin
				state_next = (CntW'(idx_q) + CntW'(2) < cnt_q) ? S_SHIFT_WB : S_SHIFT_END;
			end
			S_SHIFT_END: state_next = S_PID_RD;
			S_WR: state_next = S_PID_RD;
			S_PID_RD: state_next = S_REPORT;
			S_REPORT: state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	// Memory requests per state.
	always_comb begin
		req = '0;
		unique case (state_q)
			S_INIT: begin
				// The kernel task slot starts out cleared.
				req.wr = 1'b1;
				req.wr_addr = '0;
				req.wr_data = '0;
			end
			S_TICK_RD: begin
				req.rd = 1'b1;
				req.rd_addr = '0;
			end
			S_TICK_WB: begin
				req.rd = !last_idx;
				req.rd_addr = idx_nxt;
				req.wr = 1'b1;
				req.wr_addr = idx_q;
				req.wr_data = rd_data;
				if (rd_data.sleep != 32'd0) begin
					req.wr_data.sleep = rd_data.sleep - 32'd1;
				end
			end
			S_CUR_RD: begin
				req.rd = 1'b1;
				req.rd_addr = cur_q;
			end
			S_CUR_DONE: begin
				if (func_q == FUNC_SLEEP) begin
					req.wr = 1'b1;
					req.wr_addr = cur_q;
					req.wr_data = rd_data;
					req.wr_data.sleep = sleep_q;
				end else if (func_q == FUNC_EXIT && rd_data.parent != 8'd0) begin
					req.wr = 1'b1;
					req.wr_addr = cur_q;
					req.wr_data = rd_data;
					req.wr_data.zombie = 1'b1;
				end
			end
			S_SCAN_RD: begin
				req.rd = 1'b1;
				req.rd_addr = '0;
			end
			S_SCAN_CHK: begin
				req.rd = !scan_hit && !last_idx;
				req.rd_addr = idx_nxt;
				if (scan_hit && func_q == FUNC_EXIT) begin
					// Wake the parent.
					req.wr = 1'b1;
					req.wr_addr = idx_q;
					req.wr_data = rd_data;
					req.wr_data.sleep = 32'd0;
				end else if (!scan_hit && last_idx && func_q == FUNC_WAIT) begin
					// No zombie child: the caller sleeps.
					req.wr = 1'b1;
					req.wr_addr = cur_q;
					req.wr_data = cur_ent_q;
					req.wr_data.sleep = 32'(wait_ticks);
				end
			end
			S_SHIFT_RD: begin
				req.rd = 1'b1;
				req.rd_addr = rm_q + SlotW'(1);
			end
			S_SHIFT_WB: begin
				req.rd = CntW'(idx_q) + CntW'(2) < cnt_q;
				req.rd_addr = idx_q + SlotW'(2);
				req.wr = 1'b1;
				req.wr_addr = idx_q;
				req.wr_data = rd_data;
			end
			S_WR: begin
				req.wr = 1'b1;
				req.wr_addr = cnt_q[SlotW-1:0];
				req.wr_data = '{pid: 8'(cnt_q + CntW'(1)), parent: parent_q,
					sleep: 32'd0, zombie: 1'b0, runnable: runnable_q};
			end
			S_PID_RD: begin
				req.rd = 1'b1;
				req.rd_addr = cur_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			func_q <= '0;
			sleep_q <= '0;
			parent_q <= '0;
			runnable_q <= 1'b0;
			cur_q <= '0;
			cnt_q <= CntW'(1);
			idx_q <= '0;
			rm_q <= '0;
			aft_q <= '0;
			aft_v_q <= 1'b0;
			bef_q <= '0;
			bef_v_q <= 1'b0;
			key_q <= '0;
			cur_ent_q <= '0;
			sw_q <= 1'b0;
			st_q <= ST_NONE;
			res_q <= '0;
			done <= 1'b0;
			switch_now <= 1'b0;
			current_pid <= '0;
			result_pid <= '0;
			status <= '0;
			halted <= 1'b0;
		end else begin
			state_q <= state_next;
			done <= (state_q == S_REPORT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q <= func;
						sleep_q <= sleep_count;
						parent_q <= new_parent;
						runnable_q <= new_runnable;
						sw_q <= 1'b0;
						res_q <= 8'd0;
						aft_v_q <= 1'b0;
						bef_v_q <= 1'b0;
						if (cnt_q != '0 && func == FUNC_CREATE && cnt_q >= CntW'(MaxTasks)) begin
							st_q <= ST_FULL;
						end else begin
							st_q <= ST_NONE;
						end
					end
				end
				S_TICK_RD: begin
					idx_q <= '0;
				end
				S_TICK_WB: begin
					if (tick_hit) begin
						if (idx_q > cur_q) begin
							if (!aft_v_q) begin
								aft_q <= idx_q;
								aft_v_q <= 1'b1;
							end
						end else if (!bef_v_q) begin
							bef_q <= idx_q;
							bef_v_q <= 1'b1;
						end
					end
					idx_q <= idx_nxt;
				end
				S_TICK_DONE: begin
					if (tick_v && tick_sel != cur_q) begin
						cur_q <= tick_sel;
						sw_q <= 1'b1;
						st_q <= ST_OK;
					end
				end
				S_CUR_DONE: begin
					key_q <= (func_q == FUNC_EXIT) ? rd_data.parent : rd_data.pid;
					cur_ent_q <= rd_data;
					rm_q <= cur_q;
					if (func_q == FUNC_SLEEP || func_q == FUNC_EXIT) begin
						st_q <= ST_OK;
					end
				end
				S_SCAN_RD: begin
					idx_q <= '0;
				end
				S_SCAN_CHK: begin
					if (scan_hit && func_q == FUNC_WAIT) begin
						res_q <= rd_data.pid;
						st_q <= ST_OK;
						rm_q <= idx_q;
					end
					idx_q <= idx_nxt;
				end
				S_SHIFT_RD: begin
					idx_q <= rm_q;
				end
				S_SHIFT_WB: begin
					idx_q <= idx_nxt;
				end
				S_SHIFT_END: begin
					// The entry is gone; place the current slot in the shorter table.
					cnt_q <= cnt_dec;
					if (func_q == FUNC_EXIT) begin
						cur_q <= exit_cur;
						sw_q <= (cnt_dec != '0);
					end else if (rm_q == cur_q) begin
						if (CntW'(cur_q) >= cnt_dec) begin
							cur_q <= '0;
						end
						sw_q <= (cnt_dec != '0);
					end else if (cur_q > rm_q) begin
						cur_q <= cur_q - SlotW'(1);
					end
				end
				S_WR: begin
					cnt_q <= cnt_q + CntW'(1);
					res_q <= 8'(cnt_q + CntW'(1));
					st_q <= ST_OK;
				end
				S_REPORT: begin
					switch_now <= sw_q;
					current_pid <= (cnt_q == '0) ? 8'd0 : rd_data.pid;
					result_pid <= res_q;
					status <= st_q;
					halted <= (cnt_q == '0);
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

/* rtl/core/rrts_checker.sv */
// Port checker for the task scheduler, bound to the top level.
`default_nettype none
module rrts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic halted,
	input wire logic [7:0] current_pid
);
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe longer than one cycle");
	a_halt_pid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && halted) |-> (current_pid == 8'd0)) else $error("halted with pid");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3)) else $error("bad status");
endmodule

bind round_robin_task_scheduler_unit rrts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .halted(halted), .current_pid(current_pid)
);
`default_nettype wire
